>>> rtl/positional_ordered_list_assert.svh
// Assertion macros for the positional ordered list block.
// Included by positional_ordered_list.sv, which carries the concurrent checks; no other dependency.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk_i while out of reset.
`define POL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("positional_ordered_list: assertion failed");

// Checked on every rising edge of clk_i, reset included.
`define POL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("positional_ordered_list: assertion failed");

`else

`define POL_ASSERT(lbl, prop)
`define POL_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/pol_pkg.sv
// Shared types and constants of the positional ordered list block.
// Used by pol_cell, positional_ordered_list and the bench; depends on nothing else.
`default_nettype none

package pol_pkg;

  // List capacity and derived widths.
  localparam int Capacity = 16;
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int IdxW     = $clog2(Capacity);
  localparam int PosW     = 5;
  localparam int LenW     = 5;
  localparam int DataW    = 32;
  localparam int OpW      = 3;
  localparam int StatusW  = 2;
  // Common width for comparing positions against the count.
  localparam int CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE   = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins;
    logic            del;
    logic [CmpW-1:0] pos;
    logic [DataW-1:0] value;
  } pol_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pol_cell.sv
// One storage cell of the list chain: holds one entry and takes data from
// its left or right neighbor on a shift. Depends on pol_pkg.
`default_nettype none

module pol_cell (
  input  wire logic                     clk_i,
  input  wire logic [pol_pkg::IdxW-1:0] idx_i,
  input  wire pol_pkg::pol_ctrl_t       ctrl_i,
  input  wire logic [pol_pkg::DataW-1:0] left_i,
  input  wire logic [pol_pkg::DataW-1:0] right_i,
  output logic [pol_pkg::DataW-1:0]     data_o,
  output logic [pol_pkg::DataW-1:0]     next_o
);
  import pol_pkg::*;

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;
  logic [CmpW-1:0]  idx_ext;

  assign idx_ext = CmpW'(idx_i);

  // An insert loads the value at its position and shifts the tail right;
  // a delete pulls the tail one place left from the position on.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx_ext == ctrl_i.pos) begin
        data_d = ctrl_i.value;
      end else if (idx_ext > ctrl_i.pos) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del) begin
      if (idx_ext >= ctrl_i.pos) begin
        data_d = right_i;
      end
    end
  end

  // Entry storage needs no reset: it is read only after being written.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

`default_nettype wire

>>> rtl/positional_ordered_list.sv
// Positional ordered list: input and result channels with valid/ready.
//
// Each input transaction carries an operation (insert front, back or at a
// position; delete front, back or at a position), a value and a position.
// Each one produces exactly one result transaction with a status, the new
// length and the value now at the front of the list (0 when empty).
//
// The list lives in a row of Capacity cells. All cells shift or hold in the
// same cycle, so an operation completes in the cycle it is accepted and its
// result appears on the output register in the cycle after. One transaction
// is taken per cycle unless the receiver stalls.
//
// Reset empties the list; entry contents stay undefined until written.
// When the receiver stalls, the result waits in the output register and
// in_ready_o drops until it is taken; a new transaction is accepted in the
// same cycle that the waiting result leaves.
// Depends on pol_pkg, pol_cell and positional_ordered_list_assert.svh.
`default_nettype none

`include "positional_ordered_list_assert.svh"

module positional_ordered_list (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [pol_pkg::OpW-1:0]     operation_i,
  input  wire logic signed [pol_pkg::DataW-1:0] value_i,
  input  wire logic [pol_pkg::PosW-1:0]    position_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [pol_pkg::StatusW-1:0]      status_o,
  output logic [pol_pkg::LenW-1:0]         length_o,
  output logic signed [pol_pkg::DataW-1:0] front_value_o
);
  import pol_pkg::*;

  logic            in_fire;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [LenW-1:0] length_q;
  logic [DataW-1:0] front_q, front_d;
  pol_ctrl_t       ctrl;
  logic [CmpW-1:0] cnt_ext, pos_ext, pos_eff;
  logic            is_ins, is_del;
  logic [DataW-1:0] cell_q [Capacity];
  logic [DataW-1:0] cell_d [Capacity];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cnt_ext    = CmpW'(count_q);
  assign pos_ext    = CmpW'(position_i);

  // Decode the operation into an effective position and a command.
  always_comb begin
    is_ins  = 1'b0;
    is_del  = 1'b0;
    pos_eff = '0;
    case (op_e'(operation_i))
      OP_INS_FRONT: begin is_ins = 1'b1; pos_eff = '0; end
      OP_INS_BACK:  begin is_ins = 1'b1; pos_eff = cnt_ext; end
      OP_INS_POS:   begin is_ins = 1'b1; pos_eff = pos_ext; end
      OP_DEL_FRONT: begin is_del = 1'b1; pos_eff = '0; end
      OP_DEL_BACK:  begin is_del = 1'b1; pos_eff = cnt_ext - CmpW'(1); end
      OP_DEL_POS:   begin is_del = 1'b1; pos_eff = pos_ext; end
      default:      begin is_ins = 1'b0; end
    endcase
  end

  // Check bounds, fill level and emptiness; build the cell command.
  always_comb begin
    status_d   = ST_DONE;
    count_d    = count_q;
    ctrl.ins   = 1'b0;
    ctrl.del   = 1'b0;
    ctrl.pos   = pos_eff;
    ctrl.value = value_i;
    if (is_ins) begin
      if (pos_eff > cnt_ext) begin
        status_d = ST_BOUNDS;
      end else if (cnt_ext == CmpW'(Capacity)) begin
        status_d = ST_FULL;
      end else begin
        ctrl.ins = in_fire;
        count_d  = count_q + CntW'(1);
      end
    end else if (is_del) begin
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else if (pos_eff >= cnt_ext) begin
        status_d = ST_BOUNDS;
      end else begin
        ctrl.del = in_fire;
        count_d  = count_q - CntW'(1);
      end
    end
  end

  // The chain of cells; the ends see their own entry as the missing neighbor.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cell_q[i];
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end
    pol_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(i)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_q[i]),
      .next_o  (cell_d[i])
    );
  end

  assign front_d = (count_d == '0) ? '0 : cell_d[0];

  // List length and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      length_q <= LenW'(count_d);
      front_q  <= front_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign length_o      = length_q;
  assign front_value_o = front_q;

  `POL_ASSERT(a_count_in_range, count_q <= CntW'(Capacity))
  `POL_ASSERT(a_fire_gives_result, in_fire |=> out_valid_q)
  `POL_ASSERT(a_insert_grows, (in_fire && ctrl.ins) |=> (count_q == $past(count_q) + CntW'(1)))
  `POL_ASSERT(a_refused_keeps_count,
              (in_fire && status_d != ST_DONE) |=> (count_q == $past(count_q)))
  `POL_ASSERT_ALWAYS(a_no_cmd_when_idle, !in_fire |-> (!ctrl.ins && !ctrl.del))

endmodule

`default_nettype wire

>>> bench/tb_positional_ordered_list.sv
// Self-checking bench for the positional ordered list: directed corner items, then
// biased random insert/delete traffic with random stalls on both channels.
// Depends on pol_pkg and the positional_ordered_list RTL only.
`timescale 1ns / 1ps

module tb_positional_ordered_list;
  import pol_pkg::*;

  // Operation codes the block does not define; they must leave the list alone.
  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  localparam int RandomItems = 1875;
  localparam int QuietTail   = 150;
  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 10;
  localparam int CycleLimit  = 200000;

  typedef struct {
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         pos;
  } list_cmd_t;

  typedef struct {
    status_e                 status;
    logic [LenW-1:0]         length;
    logic signed [DataW-1:0] front;
  } list_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [OpW-1:0]          operation_i = '0;
  logic signed [DataW-1:0] value_i = '0;
  logic [PosW-1:0]         position_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [StatusW-1:0]      status_o;
  logic [LenW-1:0]         length_o;
  logic signed [DataW-1:0] front_value_o;

  positional_ordered_list dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .length_o     (length_o),
    .front_value_o(front_value_o)
  );

  // Shadow copy of the list used for prediction.
  logic signed [DataW-1:0] shadow_words [Capacity];
  int                      shadow_count = 0;

  list_cmd_t    cmd_queue [$];
  list_result_t expected_results [$];

  logic cmd_taken = 1'b0;
  logic hold_off = 1'b0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   send_gap_pct = 20;
  int   recv_gap_pct = 20;
  int   cycle_count = 0;
  int   accepted_count = 0;
  int   result_count = 0;
  int   error_count = 0;
  int   status_seen [4] = '{0, 0, 0, 0};
  int   deepest_fill = 0;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Insert a word at a list position, shifting the tail back by one place.
  function automatic status_e insert_word(int at, logic signed [DataW-1:0] value);
    if (at > shadow_count) return ST_BOUNDS;
    if (shadow_count >= Capacity) return ST_FULL;
    for (int i = shadow_count; i > at; i--) shadow_words[i] = shadow_words[i-1];
    shadow_words[at] = value;
    shadow_count++;
    return ST_DONE;
  endfunction

  // Remove the word at a list position, pulling the tail forward by one place.
  function automatic status_e remove_word(int at);
    if (shadow_count == 0) return ST_EMPTY;
    if (at >= shadow_count) return ST_BOUNDS;
    for (int i = at; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
    shadow_count--;
    return ST_DONE;
  endfunction

  // Apply one operation to the shadow list and return the result it must produce.
  function automatic list_result_t apply_list_op(logic [OpW-1:0] op,
                                                 logic signed [DataW-1:0] value,
                                                 logic [PosW-1:0] pos);
    list_result_t res;
    status_e      st;
    st = ST_DONE;
    case (op)
      OP_INS_FRONT: st = insert_word(0, value);
      OP_INS_BACK:  st = insert_word(shadow_count, value);
      OP_INS_POS:   st = insert_word(int'(pos), value);
      OP_DEL_FRONT: st = remove_word(0);
      OP_DEL_BACK:  st = remove_word(shadow_count == 0 ? 0 : shadow_count - 1);
      OP_DEL_POS:   st = remove_word(int'(pos));
      default:      st = ST_DONE;
    endcase
    res.status = st;
    res.length = LenW'(shadow_count);
    res.front  = (shadow_count == 0) ? '0 : shadow_words[0];
    return res;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(string field, longint got, longint want);
    if (error_count < 100)
      $display("Mismatch in %s at result %0d: got %0d, expected %0d",
               field, result_count, got, want);
    error_count++;
  endtask

  task automatic push_cmd(logic [OpW-1:0] op, logic signed [DataW-1:0] value,
                          logic [PosW-1:0] pos);
    list_cmd_t c;
    c.op    = op;
    c.value = value;
    c.pos   = pos;
    cmd_queue.push_back(c);
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Sample both channels at the rising edge: predict on input transactions, check results.
  always @(posedge clk_i) begin
    list_result_t want;
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Verification failed");
      $finish;
    end
    if (!rst_ni) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_list_op(operation_i, value_i, position_i));
        accepted_count++;
        if (shadow_count > deepest_fill) deepest_fill = shadow_count;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", longint'(status_o), longint'(want.status));
          if (length_o !== want.length)
            report_mismatch("length", longint'(length_o), longint'(want.length));
          if (front_value_o !== want.front)
            report_mismatch("front_value", longint'(front_value_o), longint'(want.front));
          status_seen[want.status]++;
        end
        result_count++;
      end
    end
  end

  // Input driver: offers the head of the command queue, with random idle bursts.
  always @(negedge clk_i) begin
    logic      drive_valid;
    list_cmd_t head;
    if (rst_ni && (!in_valid_i || cmd_taken)) begin
      if (in_valid_i) void'(cmd_queue.pop_front());
      if (cycle_count % 64 == 0) send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      drive_valid = 1'b0;
      if (send_idle > 0) begin
        send_idle--;
      end else if (cmd_queue.size() > QuietTail && $urandom_range(0, 99) < send_gap_pct) begin
        send_idle = $urandom_range(0, 3);
      end else if (cmd_queue.size() > 0) begin
        drive_valid = 1'b1;
      end
      in_valid_i <= drive_valid;
      if (drive_valid) begin
        head = cmd_queue[0];
        operation_i <= head.op;
        value_i     <= head.value;
        position_i  <= head.pos;
      end
    end
  end

  // Result receiver: random stall bursts, plus the long hold-off when requested.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cycle_count % 64 == 32) recv_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle--;
        out_ready_i <= 1'b0;
      end else if (cmd_queue.size() > QuietTail && $urandom_range(0, 99) < recv_gap_pct) begin
        recv_idle = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Hold the receiver off for a long stretch so that the block backs up its input.
  initial begin
    while (accepted_count < 400) @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  // Build the stimulus, release reset, then wait for the traffic to drain.
  initial begin
    int   made;
    int   seg_left;
    int   ins_pct;
    int   r;
    logic [OpW-1:0] op;
    logic [PosW-1:0] pos;

    // Directed: every delete on an empty list, then an out-of-range insert.
    push_cmd(OP_DEL_FRONT, 32'sd5, 5'd0);
    push_cmd(OP_DEL_BACK, 32'sd5, 5'd0);
    push_cmd(OP_DEL_POS, 32'sd5, 5'd31);
    push_cmd(OP_INS_POS, 32'sd7, 5'd1);
    // Fill the list to capacity with extreme and random values.
    push_cmd(OP_INS_FRONT, 32'sh8000_0000, 5'd0);
    push_cmd(OP_INS_BACK, 32'sh7fff_ffff, 5'd0);
    push_cmd(OP_INS_POS, -32'sd1, 5'd1);
    push_cmd(OP_INS_POS, 32'sd0, 5'd3);
    for (int i = 0; i < Capacity - 4; i++) push_cmd(OP_INS_FRONT, $urandom, 5'd0);
    // Full list: position beyond the length wins over full, then plain full cases.
    push_cmd(OP_INS_POS, 32'sd1, 5'd17);
    push_cmd(OP_INS_BACK, 32'sd1, 5'd0);
    push_cmd(OP_INS_POS, 32'sd1, 5'd16);
    // Delete at a position past the end, then the spare codes and a back delete.
    push_cmd(OP_DEL_POS, 32'sd0, 5'd16);
    push_cmd(OP_SPARE_LO, 32'sd9, 5'd3);
    push_cmd(OP_SPARE_HI, -32'sd9, 5'd31);
    push_cmd(OP_DEL_BACK, 32'sd0, 5'd0);

    // Random segments that lean toward filling, draining or a balanced mix.
    made = 0;
    seg_left = 0;
    ins_pct = 50;
    while (made < RandomItems) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       ins_pct = 85;
          1:       ins_pct = 50;
          default: ins_pct = 15;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = r[0] ? OP_SPARE_HI : OP_SPARE_LO;
      end else if ($urandom_range(0, 99) < ins_pct) begin
        case ($urandom_range(0, 2))
          0:       op = OP_INS_FRONT;
          1:       op = OP_INS_BACK;
          default: op = OP_INS_POS;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_DEL_FRONT;
          1:       op = OP_DEL_BACK;
          default: op = OP_DEL_POS;
        endcase
      end
      if ($urandom_range(0, 9) == 0) pos = PosW'($urandom_range(17, 31));
      else pos = PosW'($urandom_range(0, $urandom_range(0, 16)));
      push_cmd(op, pick_value(), pos);
      made++;
      seg_left--;
    end

    // Reset is released on a falling edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d list operations and checked %0d results; deepest fill %0d of %0d.",
             accepted_count, result_count, deepest_fill, Capacity);
    $display("Statuses seen: done %0d, out of bounds %0d, full %0d, empty %0d.",
             status_seen[ST_DONE], status_seen[ST_BOUNDS], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
